// ===== sv/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg: shared definitions for the 3x3 box smoothing block
// Sizes, register codes, reciprocal constants and the request and tag types
// passed between the control logic and the mean unit.
// ----------------------------------------------------------------------------
package bsm_pkg;

  // Frame geometry
  localparam int MaxWidth       = 16;
  localparam int PixelW         = 8;
  localparam int FrameSizeW     = 5;
  localparam int FrameSizeReset = 16;
  localparam int PosW           = 4;   // width of the out_row / out_col ports
  localparam int ColW           = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int SizeW          = $clog2(MaxWidth + 1);
  localparam int CmpW           = (SizeW > FrameSizeW) ? SizeW : FrameSizeW;

  // Configuration port
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic RegFrameSize = 1'b0;  // register index, taken from paddr[2]

  // Window sum and constant division
  localparam int SumW       = $clog2(9 * 255 + 1);
  localparam int RecipW     = 14;
  localparam int RecipShift = 16;
  localparam logic [RecipW-1:0] Recip6 = RecipW'(((1 << RecipShift) + 5) / 6);
  localparam logic [RecipW-1:0] Recip9 = RecipW'(((1 << RecipShift) + 8) / 9);

  // Line buffer word: {upper line, middle line}
  localparam int LineWordW = 2 * PixelW;

  typedef enum logic [1:0] {
    DIV4 = 2'd0,
    DIV6 = 2'd1,
    DIV9 = 2'd2
  } div_e;

  typedef struct packed {
    logic [ColW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } tag_t;

  typedef struct packed {
    logic [8:0][PixelW-1:0] win;       // [r*3+k]: rows i-2..i, cols j-2..j
    logic [2:0]             row_mask;  // bit r selects window row r
    logic [2:0]             col_mask;  // bit k selects window column k
    tag_t                   tag;
  } mean_req_t;

endpackage

// ===== sv/box_smoothing_3x3.sv =====
// ----------------------------------------------------------------------------
// box_smoothing_3x3: streaming 3x3 box filter over a square frame
// Takes pixels in raster order and returns the truncated mean of each
// pixel's 3x3 neighborhood, clipped at the frame border.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / pixel_i) carries one pixel per
//   transaction in raster order. Output channel (out_valid_o / out_stall_i)
//   carries one smoothed pixel with its row and column; last_o marks the
//   final result caused by one input pixel. A pixel yields zero to four
//   results.
//   The two previous rows live in one line buffer RAM read at the pixel's
//   column and written back on the next cycle. Each pixel does this
//   read-modify-write, then issues its results one at a time as the mean
//   unit accepts them; the next pixel is taken only after the last is issued.
//   The first result passes the window load, the sum stage and the divide
//   into the output register, where it can be taken.
//   frame_size sits at APB address 0; a write restarts the frame at row 0,
//   column 0. Write it only while the block is idle.
//   Reset clears position, window and the control state; frame size goes
//   back to 16. Line buffer contents need no clearing.
//   When the receiver stalls, the output register holds and the mean unit
//   fills up, after which the block stops taking pixels.
// ----------------------------------------------------------------------------
module box_smoothing_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bsm_pkg::PixelW-1:0]    pixel_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bsm_pkg::PixelW-1:0]    smoothed_o,
  output logic [bsm_pkg::PosW-1:0]      out_row_o,
  output logic [bsm_pkg::PosW-1:0]      out_col_o,
  output logic                          last_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsm_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bsm_pkg::ApbDataW-1:0]  pwdata,
  output logic [bsm_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                                state_q, state_d;
  logic [bsm_pkg::FrameSizeW-1:0]        frame_size_q;
  logic [bsm_pkg::ColW-1:0]              row_q;
  logic [bsm_pkg::ColW-1:0]              col_q;
  logic [8:0][bsm_pkg::PixelW-1:0]       win_q, win_d;
  logic [3:0]                            job_q, job_d;
  logic [bsm_pkg::PixelW-1:0]            pix_q;

  logic                                  in_accept;
  logic                                  cfg_wr;
  logic [bsm_pkg::CmpW-1:0]              fs_ext;
  logic [bsm_pkg::CmpW-1:0]              eff_size;
  logic [bsm_pkg::CmpW-1:0]              size_m1;
  logic                                  last_col;
  logic                                  last_row;
  logic                                  row_ge1;
  logic                                  row_ge2;
  logic                                  col_ge1;
  logic                                  col_ge2;
  logic [3:0]                            jobs_new;
  logic [3:0]                            sel_oh;
  logic                                  sel_pass;
  logic                                  sel_right;
  logic                                  adv_pos;
  logic                                  ram_re;
  logic                                  ram_we;
  logic [bsm_pkg::LineWordW-1:0]         ram_rdata;
  logic [bsm_pkg::PixelW-1:0]            upper_rd;
  logic [bsm_pkg::PixelW-1:0]            middle_rd;
  logic                                  req_valid;
  logic                                  req_ready;
  bsm_pkg::mean_req_t                    req;
  bsm_pkg::tag_t                         out_tag;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bsm_pkg::RegFrameSize);
  assign prdata = (paddr[2] == bsm_pkg::RegFrameSize) ?
                  bsm_pkg::ApbDataW'(frame_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q <= bsm_pkg::FrameSizeW'(bsm_pkg::FrameSizeReset);
    end else if (cfg_wr) begin
      frame_size_q <= pwdata[bsm_pkg::FrameSizeW-1:0];
    end
  end

  // Clamp frame size to [2, MaxWidth]
  assign fs_ext   = bsm_pkg::CmpW'(frame_size_q);
  assign eff_size = (fs_ext < bsm_pkg::CmpW'(2)) ? bsm_pkg::CmpW'(2) :
                    (fs_ext > bsm_pkg::CmpW'(bsm_pkg::MaxWidth)) ?
                    bsm_pkg::CmpW'(bsm_pkg::MaxWidth) : fs_ext;
  assign size_m1  = eff_size - bsm_pkg::CmpW'(1);

  // Position flags of the current pixel
  assign last_col = (bsm_pkg::CmpW'(col_q) == size_m1);
  assign last_row = (bsm_pkg::CmpW'(row_q) == size_m1);
  assign row_ge1  = (row_q != '0);
  assign col_ge1  = (col_q != '0);
  assign row_ge2  = (bsm_pkg::CmpW'(row_q) > bsm_pkg::CmpW'(1));
  assign col_ge2  = (bsm_pkg::CmpW'(col_q) > bsm_pkg::CmpW'(1));

  // Results caused by this pixel, in output order:
  // row above left, row above own column, same row left, same row own column
  assign jobs_new = {last_row && last_col, last_row && col_ge1,
                     row_ge1 && last_col,  row_ge1 && col_ge1};

  // Lowest pending result first
  assign sel_oh    = job_q & (~job_q + 4'd1);
  assign sel_pass  = sel_oh[2] | sel_oh[3];
  assign sel_right = sel_oh[1] | sel_oh[3];

  // Line buffer: word holds {upper, middle}
  assign upper_rd  = ram_rdata[bsm_pkg::LineWordW-1 -: bsm_pkg::PixelW];
  assign middle_rd = ram_rdata[bsm_pkg::PixelW-1:0];

  bsm_line_ram #(
    .Depth (bsm_pkg::MaxWidth),
    .Width (bsm_pkg::LineWordW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i ({middle_rd, pix_q}),
    .re_i    (ram_re),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer: read line buffer, shift window and write back, then issue results
  always_comb begin
    int r;
    state_d   = state_q;
    job_d     = job_q;
    win_d     = win_q;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    adv_pos   = 1'b0;
    req_valid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          ram_re  = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ram_we = 1'b1;
        for (r = 0; r < 3; r++) begin
          win_d[r*3+0] = win_q[r*3+1];
          win_d[r*3+1] = win_q[r*3+2];
        end
        win_d[2] = upper_rd;
        win_d[5] = middle_rd;
        win_d[8] = pix_q;
        job_d    = jobs_new;
        if (jobs_new == '0) begin
          adv_pos = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        req_valid = 1'b1;
        if (req_ready) begin
          job_d = job_q & ~sel_oh;
          if ((job_q & ~sel_oh) == '0) begin
            adv_pos = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= '0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      win_q   <= win_d;
    end
  end

  // Capture the pixel of the accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pix_q <= pixel_i;
    end
  end

  // Advance raster position, restart on a configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_wr) begin
      row_q <= '0;
      col_q <= '0;
    end else if (adv_pos) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + bsm_pkg::ColW'(1);
      end else begin
        col_q <= col_q + bsm_pkg::ColW'(1);
      end
    end
  end

  // Build the mean request for the selected result
  always_comb begin
    req.win      = win_q;
    req.row_mask = sel_pass  ? 3'b110 : {2'b11, row_ge2};
    req.col_mask = sel_right ? 3'b110 : {2'b11, col_ge2};
    req.tag.row  = sel_pass  ? row_q : row_q - bsm_pkg::ColW'(1);
    req.tag.col  = sel_right ? col_q : col_q - bsm_pkg::ColW'(1);
    req.tag.last = ((job_q & ~sel_oh) == '0);
  end

  bsm_mean_unit u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .smoothed_o  (smoothed_o),
    .tag_o       (out_tag)
  );

  assign out_row_o = bsm_pkg::PosW'(out_tag.row);
  assign out_col_o = bsm_pkg::PosW'(out_tag.col);
  assign last_o    = out_tag.last;

  // Line buffer write-back follows a pixel accepted in the previous cycle
  a_wb_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> $past(in_accept))
    else $error("line buffer write without a preceding pixel");

  // Result issue always has pending work
  a_emit_has_jobs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (job_q != '0))
    else $error("result issue with nothing pending");

  // Raster position moves only when a pixel retires or on a register write
  a_pos_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(col_q) |-> $past(adv_pos || cfg_wr))
    else $error("raster position changed unexpectedly");

  // No new pixel is taken while results of the previous one are pending
  a_no_accept_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (job_q == '0))
    else $error("pixel accepted with results pending");

endmodule

// ===== sv/bsm_line_ram.sv =====
// ----------------------------------------------------------------------------
// bsm_line_ram: line buffer memory
// Simple dual-port synchronous RAM with one write and one read port and
// registered read data.
// ----------------------------------------------------------------------------
module bsm_line_ram #(
  parameter int Depth = 16,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bsm_mean_unit.sv =====
// ----------------------------------------------------------------------------
// bsm_mean_unit: clipped window mean
// Stage one sums the selected window pixels; stage two divides by 4 with a shift
// or by 6 or 9 with a reciprocal multiply and holds the result in the output register.
// ----------------------------------------------------------------------------
module bsm_mean_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  bsm_pkg::mean_req_t        req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bsm_pkg::PixelW-1:0] smoothed_o,
  output bsm_pkg::tag_t             tag_o
);

  logic                                        s1_valid_q;
  logic [bsm_pkg::SumW-1:0]                    s1_sum_q;
  bsm_pkg::div_e                               s1_div_q;
  bsm_pkg::tag_t                               s1_tag_q;
  logic                                        out_valid_q;
  logic [bsm_pkg::PixelW-1:0]                  out_pix_q;
  bsm_pkg::tag_t                               out_tag_q;

  logic                                        out_free;
  logic                                        s1_adv;
  logic                                        req_fire;
  logic [bsm_pkg::SumW-1:0]                    sum;
  bsm_pkg::div_e                               div;
  logic [bsm_pkg::RecipW-1:0]                  recip;
  logic [bsm_pkg::SumW+bsm_pkg::RecipW-1:0]    prod;
  logic [bsm_pkg::PixelW-1:0]                  quot;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_adv      = s1_valid_q && out_free;
  assign req_ready_o = !s1_valid_q || out_free;
  assign req_fire    = req_valid_i && req_ready_o;

  // Sum the pixels inside the clipped neighborhood
  always_comb begin
    int r;
    int k;
    sum = '0;
    for (r = 0; r < 3; r++) begin
      for (k = 0; k < 3; k++) begin
        if (req_i.row_mask[r] && req_i.col_mask[k]) begin
          sum = sum + bsm_pkg::SumW'(req_i.win[r*3+k]);
        end
      end
    end
  end

  // Pick the divisor from the number of rows and columns kept
  always_comb begin
    if (&req_i.row_mask && &req_i.col_mask) begin
      div = bsm_pkg::DIV9;
    end else if (&req_i.row_mask || &req_i.col_mask) begin
      div = bsm_pkg::DIV6;
    end else begin
      div = bsm_pkg::DIV4;
    end
  end

  // Stage one: hold sum, divisor and tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_ready_o) begin
      s1_valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_sum_q <= sum;
      s1_div_q <= div;
      s1_tag_q <= req_i.tag;
    end
  end

  // Divide by a constant: shift for 4, reciprocal multiply for 6 and 9
  assign recip = (s1_div_q == bsm_pkg::DIV6) ? bsm_pkg::Recip6 : bsm_pkg::Recip9;
  assign prod  = (bsm_pkg::SumW+bsm_pkg::RecipW)'(s1_sum_q) *
                 (bsm_pkg::SumW+bsm_pkg::RecipW)'(recip);

  always_comb begin
    case (s1_div_q)
      bsm_pkg::DIV4: quot = bsm_pkg::PixelW'(s1_sum_q >> 2);
      bsm_pkg::DIV6,
      bsm_pkg::DIV9: quot = prod[bsm_pkg::RecipShift +: bsm_pkg::PixelW];
      default:       quot = '0;
    endcase
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pix_q <= quot;
      out_tag_q <= s1_tag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = out_pix_q;
  assign tag_o       = out_tag_q;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 box smoothing block
// Streams square frames of pixels through the block at several frame sizes
// (out-of-range codes included), predicts every smoothed pixel with its
// row, column and last flag, and checks the results in order. Both sides
// idle at random; one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit     = 500000;
  localparam int SettleCycles   = 24;
  localparam int LongHoldCycles = 300;
  localparam int TotalItems     = 410;
  localparam logic [bsm_pkg::ApbAddrW-1:0] FrameSizeAddr = {bsm_pkg::RegFrameSize, 2'b00};

  typedef struct packed {
    logic [bsm_pkg::PixelW-1:0] smoothed;
    logic [bsm_pkg::PosW-1:0]   row;
    logic [bsm_pkg::PosW-1:0]   col;
    logic                       last;
  } smooth_result_t;

  // DUT signals; the inputs driven by the bench are known from time zero
  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [bsm_pkg::PixelW-1:0]   pixel_i     = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [bsm_pkg::PixelW-1:0]   smoothed_o;
  logic [bsm_pkg::PosW-1:0]     out_row_o;
  logic [bsm_pkg::PosW-1:0]     out_col_o;
  logic                         last_o;
  logic                         psel        = 1'b0;
  logic                         penable     = 1'b0;
  logic                         pwrite      = 1'b0;
  logic [bsm_pkg::ApbAddrW-1:0] paddr       = '0;
  logic [bsm_pkg::ApbDataW-1:0] pwdata      = '0;
  logic [bsm_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  // Stimulus and scoreboard
  logic [bsm_pkg::PixelW-1:0] pixel_queue[$];
  smooth_result_t             expected_means[$];
  bit                         sender_idle_on   = 1'b0;
  bit                         receiver_idle_on = 1'b0;
  int                         hold_requests    = 0;
  int                         holds_started;
  int                         gap_left;
  int                         stall_left;
  int                         hold_left;
  int                         errors           = 0;
  int                         pixels_sent      = 0;
  int                         results_checked  = 0;
  int                         size_writes      = 0;
  int                         cycle_count      = 0;

  // Predictor state
  logic [bsm_pkg::FrameSizeW-1:0] frame_reg = bsm_pkg::FrameSizeW'(bsm_pkg::FrameSizeReset);
  logic [bsm_pkg::PixelW-1:0]     upper_mem[bsm_pkg::MaxWidth];
  logic [bsm_pkg::PixelW-1:0]     middle_mem[bsm_pkg::MaxWidth];
  logic [bsm_pkg::PixelW-1:0]     window[9];
  int                             cur_row = 0;
  int                             cur_col = 0;

  box_smoothing_3x3 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .smoothed_o  (smoothed_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .last_o      (last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Clamp a frame size code to the supported range
  function automatic int effective_size(input logic [bsm_pkg::FrameSizeW-1:0] code);
    if (code < 2) return 2;
    if (code > bsm_pkg::MaxWidth) return bsm_pkg::MaxWidth;
    return int'(code);
  endfunction

  // Mean of the window entries that fall inside both the frame and the
  // 3x3 neighborhood of (orow, ocol); window row r is row i-2+r, column k is j-2+k
  function automatic logic [bsm_pkg::PixelW-1:0] neighborhood_mean(input int n, input int i,
                                                                   input int j,
                                                                   input int orow,
                                                                   input int ocol);
    int sum;
    int cnt;
    int prow;
    int pcol;
    sum = 0;
    cnt = 0;
    for (int r = 0; r < 3; r++) begin
      prow = i - 2 + r;
      if (prow < 0 || prow >= n || prow < orow - 1 || prow > orow + 1) continue;
      for (int k = 0; k < 3; k++) begin
        pcol = j - 2 + k;
        if (pcol < 0 || pcol >= n || pcol < ocol - 1 || pcol > ocol + 1) continue;
        sum += window[r * 3 + k];
        cnt++;
      end
    end
    if (cnt == 0) return '0;
    return bsm_pkg::PixelW'(sum / cnt);
  endfunction

  // Advance the predictor by one pixel and queue the results it causes
  function automatic void smooth_pixel(input logic [bsm_pkg::PixelW-1:0] px);
    int n;
    int i;
    int j;
    int orow;
    int cnt;
    int rows[4];
    int cols[4];
    smooth_result_t res;
    n = effective_size(frame_reg);
    if (cur_row >= n || cur_col >= n) begin
      cur_row = 0;
      cur_col = 0;
    end
    i = cur_row;
    j = cur_col;
    for (int r = 0; r < 3; r++) begin
      window[r * 3]     = window[r * 3 + 1];
      window[r * 3 + 1] = window[r * 3 + 2];
    end
    window[2] = upper_mem[j];
    window[5] = middle_mem[j];
    window[8] = px;
    // row above the input, and the input row itself on the last row
    cnt = 0;
    for (int pass = 0; pass < 2; pass++) begin
      orow = (pass == 0) ? i - 1 : i;
      if (orow < 0 || (pass == 1 && i != n - 1)) continue;
      if (j >= 1) begin
        rows[cnt] = orow;
        cols[cnt] = j - 1;
        cnt++;
      end
      if (j == n - 1) begin
        rows[cnt] = orow;
        cols[cnt] = j;
        cnt++;
      end
    end
    for (int k = 0; k < cnt; k++) begin
      res.smoothed = neighborhood_mean(n, i, j, rows[k], cols[k]);
      res.row      = bsm_pkg::PosW'(rows[k]);
      res.col      = bsm_pkg::PosW'(cols[k]);
      res.last     = (k == cnt - 1);
      expected_means.push_back(res);
    end
    upper_mem[j]  = middle_mem[j];
    middle_mem[j] = px;
    cur_col++;
    if (cur_col >= n) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= n) cur_row = 0;
    end
  endfunction

  // Pixel driver: take the next pixel from the queue, hold it while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      pixel_i    <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        smooth_pixel(pixel_i);
        pixels_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (sender_idle_on && pixel_queue.size() > 0 && $urandom_range(0, 9) == 0) begin
        gap_left   <= $urandom_range(0, 13);
        in_valid_i <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        pixel_i    <= pixel_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: long hold-offs on request, random bursts otherwise
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i   <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
      holds_started <= 0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_started != hold_requests) begin
      holds_started <= holds_started + 1;
      hold_left     <= LongHoldCycles;
      out_stall_i   <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result monitor: compare each accepted transaction with the oldest expectation
  always @(posedge clk_i) begin
    smooth_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_means.size() == 0) begin
        $error("unexpected result: smoothed %0d at row %0d col %0d",
               smoothed_o, out_row_o, out_col_o);
        errors++;
      end else begin
        exp_res = expected_means.pop_front();
        results_checked++;
        if (smoothed_o !== exp_res.smoothed) begin
          $error("smoothed: expected %0d, actual %0d (row %0d col %0d)",
                 exp_res.smoothed, smoothed_o, exp_res.row, exp_res.col);
          errors++;
        end
        if (out_row_o !== exp_res.row) begin
          $error("out_row: expected %0d, actual %0d", exp_res.row, out_row_o);
          errors++;
        end
        if (out_col_o !== exp_res.col) begin
          $error("out_col: expected %0d, actual %0d", exp_res.col, out_col_o);
          errors++;
        end
        if (last_o !== exp_res.last) begin
          $error("last: expected %0d, actual %0d (row %0d col %0d)",
                 exp_res.last, last_o, exp_res.row, exp_res.col);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** box_smoothing_3x3: FAILED **");
      $finish;
    end
  end

  // Write the frame size over APB, restart the predicted frame, read it back
  task automatic write_frame_size(input logic [bsm_pkg::FrameSizeW-1:0] code);
    logic [bsm_pkg::ApbDataW-1:0] word;
    word = $urandom;
    if ($urandom_range(0, 1) == 0) word = '0;
    word[bsm_pkg::FrameSizeW-1:0] = code;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FrameSizeAddr;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    frame_reg = code;
    cur_row   = 0;
    cur_col   = 0;
    size_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== bsm_pkg::ApbDataW'(code)) begin
      $error("frame_size readback: expected %0d, actual %0d", code, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every pixel is sent and every result has arrived, plus an optional settling margin
  task automatic wait_drained(input bit with_margin);
    do @(posedge clk_i);
    while (pixel_queue.size() != 0 || in_valid_i || expected_means.size() != 0);
    if (with_margin) repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic queue_pixels(input int count, input bit extremes_only);
    for (int k = 0; k < count; k++) begin
      if (extremes_only) pixel_queue.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
      else pixel_queue.push_back(bsm_pkg::PixelW'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int queued;
    int n;
    int count;
    logic [bsm_pkg::FrameSizeW-1:0] code;
    queued = 0;
    for (int k = 0; k < bsm_pkg::MaxWidth; k++) begin
      upper_mem[k]  = '0;
      middle_mem[k] = '0;
    end
    for (int k = 0; k < 9; k++) window[k] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Size code 1 acts as 2: two back-to-back frames check the wrap
    write_frame_size(5'd1);
    pixel_queue.push_back(8'hFF); pixel_queue.push_back(8'h00);
    pixel_queue.push_back(8'hFF); pixel_queue.push_back(8'hFF);
    pixel_queue.push_back(8'h00); pixel_queue.push_back(8'h00);
    pixel_queue.push_back(8'hFF); pixel_queue.push_back(8'h00);
    queued += 8;
    wait_drained(1'b1);

    // Full-scale interior mean on a 3x3 frame
    write_frame_size(5'd3);
    repeat (9) pixel_queue.push_back(8'hFF);
    queued += 9;
    wait_drained(1'b1);

    // Partial frame; the next write restarts at row 0, column 0
    write_frame_size(5'd5);
    queue_pixels(6, 1'b0);
    queued += 6;
    wait_drained(1'b1);

    // Largest frame via an over-range code, with a long hold-off and a sender pause
    sender_idle_on   <= 1'b1;
    receiver_idle_on <= 1'b1;
    write_frame_size(5'd31);
    queue_pixels(100, 1'b0);
    hold_requests++;
    queue_pixels(28, 1'b0);
    wait_drained(1'b0);
    queue_pixels(128, 1'b0);
    queued += 256;
    wait_drained(1'b1);

    // Random small frames, some cut short; no idling near the end
    while (queued < TotalItems) begin
      code  = bsm_pkg::FrameSizeW'($urandom_range(0, 8));
      n     = effective_size(code);
      count = n * n * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, n * n - 1);
      if (count > TotalItems - queued) count = TotalItems - queued;
      if (queued >= TotalItems - 60) begin
        sender_idle_on   <= 1'b0;
        receiver_idle_on <= 1'b0;
      end else begin
        sender_idle_on   <= ($urandom_range(0, 3) != 0);
        receiver_idle_on <= ($urandom_range(0, 3) != 0);
      end
      write_frame_size(code);
      queue_pixels(count, $urandom_range(0, 5) == 0);
      queued += count;
      wait_drained(1'b1);
    end

    $display("Sent %0d pixels over %0d frame size writes (codes 0 to 8 and 31),",
             pixels_sent, size_writes);
    $display("checked %0d smoothed results including a long receiver hold-off.",
             results_checked);
    if (errors == 0) begin
      $display("** box_smoothing_3x3: PASSED **");
    end else begin
      $display("** box_smoothing_3x3: FAILED **");
    end
    $finish;
  end

endmodule

// ===== box_smoothing_3x3.f =====
sv/bsm_pkg.sv
sv/bsm_line_ram.sv
sv/bsm_mean_unit.sv
sv/box_smoothing_3x3.sv
dv/testbench.sv
